FILE: hdl/wkds_pkg.sv
// Package: shared types and constants for the keyed window distinct/sum block.
package wkds_pkg;

    localparam int KEYS_DEF        = 16;
    localparam int CLIENTS_DEF     = 1024;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam logic [31:0] WINDOW_RESET = 32'd86400;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 64;
    localparam int KEYIN_W  = 4;
    localparam int CLIENT_W = 10;
    localparam int AMOUNT_W = 10;
    localparam int VALUE_W  = 18;

    typedef enum logic [1:0] {
        OP_BOOK     = 2'd0,
        OP_DISTINCT = 2'd1,
        OP_TOTAL    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_RDHEAD,
        ST_CHECK,
        ST_RDCNT,
        ST_POP,
        ST_APPEND,
        ST_RDNEW,
        ST_WRNEW,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;   // write zero at clear address, advance it
        logic load;         // capture the request
        logic rd_head;      // read queue memories at head slot
        logic rd_cnt;       // read client counter of head entry
        logic pop;          // retire the head entry
        logic append;       // write new entry, update total/fill
        logic drop;         // book hit a full queue, flag it
        logic rd_new;       // read client counter of new client
        logic wr_new;       // increment new client counter
        logic out_load;     // capture result into output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_book;
        logic is_none;
        logic empty;
        logic expired;
        logic full;
    } sts_t;

endpackage

FILE: hdl/wkds_ctrl.sv
// Controller: sequences clearing, expiry, append and result delivery.
module wkds_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  wkds_pkg::sts_t sts,
    output wkds_pkg::cmd_t cmd
);
    import wkds_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_stall  = !(state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.is_none)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RDHEAD;
                end
            end
            ST_RDHEAD:
            begin
                if (sts.empty)
                begin
                    state_next = sts.is_book ? ST_APPEND : ST_DONE;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.expired)
                begin
                    cmd.rd_cnt = 1'b1;
                    state_next = ST_RDCNT;
                end
                else
                begin
                    state_next = sts.is_book ? ST_APPEND : ST_DONE;
                end
            end
            ST_RDCNT:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_RDHEAD;
            end
            ST_APPEND:
            begin
                if (sts.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.append = 1'b1;
                    cmd.rd_new = 1'b1;
                    state_next = ST_RDNEW;
                end
            end
            ST_RDNEW:
            begin
                state_next = ST_WRNEW;
            end
            ST_WRNEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: hdl/wkds_dp.sv
// Datapath: queue memories, client counter memory, per-key registers.
module wkds_dp
#(
    parameter int KEYS        = wkds_pkg::KEYS_DEF,
    parameter int CLIENTS     = wkds_pkg::CLIENTS_DEF,
    parameter int QUEUE_DEPTH = wkds_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_length_we,
    input  logic [31:0]                    window_length_wd,
    input  logic [wkds_pkg::OP_W-1:0]      operation,
    input  logic signed [wkds_pkg::TIME_W-1:0] event_time,
    input  logic [wkds_pkg::KEYIN_W-1:0]   key_index,
    input  logic [wkds_pkg::CLIENT_W-1:0]  client,
    input  logic [wkds_pkg::AMOUNT_W-1:0]  amount,
    output logic [wkds_pkg::VALUE_W-1:0]   value,
    output logic                           status,
    input  wkds_pkg::cmd_t                 cmd,
    output wkds_pkg::sts_t                 sts
);
    import wkds_pkg::*;

    localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CNTW = FW;
    localparam int QA   = KW + QW;
    localparam int CA   = KW + CW;
    localparam int TOTW = VALUE_W;
    localparam int CLW  = (CLIENT_W > CW + 1) ? CLIENT_W : CW + 1;
    localparam int KIW  = (KEYIN_W > KW + 1) ? KEYIN_W : KW + 1;

    // Queue and counter memories
    logic [TIME_W-1:0]   qtime_mem [2**QA];
    logic [CW-1:0]       qcli_mem  [2**QA];
    logic [AMOUNT_W-1:0] qamt_mem  [2**QA];
    logic [CNTW-1:0]     cnt_mem   [2**CA];

    logic [QW-1:0]   head_reg  [KEYS];
    logic [FW-1:0]   fill_reg  [KEYS];
    logic [TOTW-1:0] total_reg [KEYS];
    logic [CNTW-1:0] dist_reg  [KEYS];

    logic [31:0]         window_reg;
    logic [TIME_W-1:0]   latest_reg;
    logic [OP_W-1:0]     op_reg;
    logic [KW-1:0]       key_reg;
    logic [CW-1:0]       cli_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   htime_reg;
    logic [CW-1:0]       hcli_reg;
    logic [AMOUNT_W-1:0] hamt_reg;
    logic [CNTW-1:0]     cnt_rd_reg;
    logic [CA:0]         clr_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                status_reg;
    logic                drop_reg;

    logic [KIW-1:0]  key_wide;
    logic [CLW-1:0]  cli_wide;
    logic [QA-1:0]   head_addr, tail_addr;
    logic [QW:0]     tail_sum;
    logic [QW-1:0]   tail_ofs;
    logic [QW-1:0]   head_inc;
    logic [CA-1:0]   hcnt_addr, ncnt_addr;
    logic [TIME_W-1:0] a_t, b_t;
    logic [TIME_W:0]   diff;
    logic            full;

    assign key_wide = KIW'(key_index);
    assign cli_wide = CLW'(client);

    // Queue offsets wrap at QUEUE_DEPTH
    assign tail_sum  = (QW+1)'(head_reg[key_reg]) + (QW+1)'(fill_reg[key_reg]);
    assign tail_ofs  = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                       QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_inc  = (head_reg[key_reg] == QW'(QUEUE_DEPTH - 1)) ?
                       '0 : head_reg[key_reg] + 1'b1;
    assign head_addr = {key_reg, head_reg[key_reg]};
    assign tail_addr = {key_reg, tail_ofs};
    assign hcnt_addr = {key_reg, hcli_reg};
    assign ncnt_addr = {key_reg, cli_reg};
    assign full      = (fill_reg[key_reg] == FW'(QUEUE_DEPTH));

    // Expired when latest - t >= window, compared in offset binary
    assign a_t  = htime_reg ^ {1'b1, {(TIME_W-1){1'b0}}};
    assign b_t  = latest_reg ^ {1'b1, {(TIME_W-1){1'b0}}};
    assign diff = {1'b0, b_t} - {1'b0, a_t};

    assign sts.clear_done = clr_reg[CA];
    assign sts.is_book    = (op_reg == OP_BOOK);
    assign sts.is_none    = (op_reg == OP_NONE);
    assign sts.empty      = (fill_reg[key_reg] == '0);
    assign sts.expired    = !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(window_reg));
    assign sts.full       = full;

    assign value  = value_reg;
    assign status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            latest_reg <= '0;
            clr_reg    <= '0;
            for (int k = 0; k < KEYS; k++)
            begin
                head_reg[k]  <= '0;
                fill_reg[k]  <= '0;
                total_reg[k] <= '0;
                dist_reg[k]  <= '0;
            end
        end
        else
        begin
            if (window_length_we)
            begin
                window_reg <= window_length_wd;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load && (operation == OP_BOOK))
            begin
                latest_reg <= event_time;
            end
            if (cmd.pop)
            begin
                head_reg[key_reg]  <= head_inc;
                fill_reg[key_reg]  <= fill_reg[key_reg] - 1'b1;
                total_reg[key_reg] <= total_reg[key_reg] - TOTW'(hamt_reg);
                if ((cnt_rd_reg == CNTW'(1)) && (dist_reg[key_reg] != '0))
                begin
                    dist_reg[key_reg] <= dist_reg[key_reg] - 1'b1;
                end
            end
            if (cmd.append)
            begin
                fill_reg[key_reg]  <= fill_reg[key_reg] + 1'b1;
                total_reg[key_reg] <= total_reg[key_reg] + TOTW'(amt_reg);
            end
            if (cmd.wr_new && (cnt_rd_reg == '0))
            begin
                dist_reg[key_reg] <= dist_reg[key_reg] + 1'b1;
            end
        end
    end

    // Request capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= KW'(key_wide % KIW'(KEYS));
            cli_reg  <= CW'(cli_wide % CLW'(CLIENTS));
            amt_reg  <= amount;
            time_reg <= event_time;
            drop_reg <= 1'b0;
        end
        else if (cmd.drop)
        begin
            drop_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            status_reg <= drop_reg;
            unique case (op_reg)
                OP_DISTINCT: value_reg <= VALUE_W'(dist_reg[key_reg]);
                OP_TOTAL:    value_reg <= total_reg[key_reg];
                default:     value_reg <= '0;
            endcase
        end
    end

    // Queue memories
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            qtime_mem[tail_addr] <= time_reg;
            qcli_mem[tail_addr]  <= cli_reg;
            qamt_mem[tail_addr]  <= amt_reg;
        end
        if (cmd.rd_head)
        begin
            htime_reg <= qtime_mem[head_addr];
            hcli_reg  <= qcli_mem[head_addr];
            hamt_reg  <= qamt_mem[head_addr];
        end
    end

    // Client counter memory: one write and one read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            cnt_mem[clr_reg[CA-1:0]] <= '0;
        end
        else if (cmd.pop && (cnt_rd_reg != '0))
        begin
            cnt_mem[hcnt_addr] <= cnt_rd_reg - 1'b1;
        end
        else if (cmd.wr_new)
        begin
            cnt_mem[ncnt_addr] <= cnt_rd_reg + 1'b1;
        end
        if (cmd.rd_cnt)
        begin
            cnt_rd_reg <= cnt_mem[hcnt_addr];
        end
        else if (cmd.rd_new)
        begin
            cnt_rd_reg <= cnt_mem[ncnt_addr];
        end
    end

endmodule

FILE: hdl/windowed_keyed_distinct_and_sum.sv
// Top level: keyed sliding-window distinct-client count and amount total.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: operation,
//   event_time, key_index, client, amount, taken at an edge with in_valid
//   high and in_stall low. Output channel (out_valid / out_stall) returns
//   exactly one result (value, status) per request. A book expires old
//   entries of its key, then appends; status is 1 when the queue is full and
//   the book is dropped. Queries expire, then report distinct clients or the
//   amount total. window_length is written through window_length_we/_wd;
//   the user must write it only while idle, the block does not enforce it.
// Sequencing:
//   One request at a time. Each request is loaded, then the head entry of
//   its key is read and checked; each expired entry has its client counter
//   read and is popped. A book then appends (or is dropped when full) and
//   counts its client; an unused operation goes straight to its result.
// Reset:
//   The client counter memory is cleared one entry a cycle, all 16384
//   entries by default; in_stall stays high meanwhile.
// Stall:
//   A result holds in the output register while out_stall is high; the next
//   request is taken but its result waits until the register frees.
module windowed_keyed_distinct_and_sum
#(
    parameter int KEYS        = wkds_pkg::KEYS_DEF,
    parameter int CLIENTS     = wkds_pkg::CLIENTS_DEF,
    parameter int QUEUE_DEPTH = wkds_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               window_length_we,
    input  logic [31:0]                        window_length_wd,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [wkds_pkg::OP_W-1:0]          operation,
    input  logic signed [wkds_pkg::TIME_W-1:0] event_time,
    input  logic [wkds_pkg::KEYIN_W-1:0]       key_index,
    input  logic [wkds_pkg::CLIENT_W-1:0]      client,
    input  logic [wkds_pkg::AMOUNT_W-1:0]      amount,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [wkds_pkg::VALUE_W-1:0]       value,
    output logic                               status
);
    import wkds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each request
    wkds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold queues, counters and result
    wkds_dp
    #(
        .KEYS        (KEYS),
        .CLIENTS     (CLIENTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_length_we (window_length_we),
        .window_length_wd (window_length_wd),
        .operation        (operation),
        .event_time       (event_time),
        .key_index        (key_index),
        .client           (client),
        .amount           (amount),
        .value            (value),
        .status           (status),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule
